>>> rtl/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants for the console line editor: character codes, command
// codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int CHAR_W        = 8;
    localparam int DEF_BUF_DEPTH = 128;

    // command field
    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_PROMPT = 1'b1;

    // register indexes
    localparam logic REG_LINE_CAPACITY = 1'b0;
    localparam logic REG_ECHO_ENABLE   = 1'b1;

    localparam logic [CHAR_W-1:0] RST_LINE_CAPACITY = 8'd128;
    localparam logic              RST_ECHO_ENABLE   = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_IGNORE  = 8'hFF;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_SQUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_DQUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

    localparam logic [CHAR_W-1:0] NO_QUOTE = 8'h00;

endpackage

>>> rtl/cle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_if
// Valid/ready channels of the console line editor: typed keys in, result
// beats out.
// ----------------------------------------------------------------------------
interface cle_key_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [cle_pkg::CHAR_W-1:0] key_char;

    modport source (output valid, output cmd, output key_char, input ready);
    modport sink   (input valid, input cmd, input key_char, output ready);
endinterface

interface cle_result_if;
    logic                      valid;
    logic                      ready;
    logic                      echo_valid;
    logic [cle_pkg::CHAR_W-1:0] echo_char;
    logic                      store_valid;
    logic [7:0]                store_index;
    logic [cle_pkg::CHAR_W-1:0] store_char;
    logic                      line_ready;
    logic                      last;

    modport source (
        output valid, output echo_valid, output echo_char, output store_valid,
        output store_index, output store_char, output line_ready, output last,
        input ready
    );
    modport sink (
        input valid, input echo_valid, input echo_char, input store_valid,
        input store_index, input store_char, input line_ready, input last,
        output ready
    );
endinterface

>>> rtl/console_line_editor.sv
`timescale 1ns / 1ps
// Path: a key is captured in the input register, and its first result beat is
// then loaded into the result register, waiting while that register is busy.
// Throughput: one key per cycle, but a key that gives a beat waits while the result
// register is busy; a backspace holds it for its three beats, others give at most one.
// Reset clears the write position, the open quote and all handshake state;
// registers take their default values. The line buffer is not cleared.
// ----------------------------------------------------------------------------
// console_line_editor
// Collects typed characters into a line buffer with backspace, quote
// tracking, upper-case folding outside quotes and console echo.
// ----------------------------------------------------------------------------
module console_line_editor #(
    parameter int BUF_DEPTH = cle_pkg::DEF_BUF_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cle_key_if.sink                    key,
    cle_result_if.source               result,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [cle_pkg::CHAR_W-1:0] cfg_data
);

    localparam int DEPTH = BUF_DEPTH + 1;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = (PW > cle_pkg::CHAR_W) ? PW : cle_pkg::CHAR_W;

    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_MID   = 2'd1;
    localparam logic [1:0] BEAT_LAST  = 2'd2;

    // configuration
    logic [cle_pkg::CHAR_W-1:0] line_cap_reg;
    logic                       echo_en_reg;

    // input register
    logic                       in_vld_reg;
    logic                       in_cmd_reg;
    logic [cle_pkg::CHAR_W-1:0] in_char_reg;

    // editor state
    logic [PW-1:0]              pos_reg, pos_next;
    logic [cle_pkg::CHAR_W-1:0] quote_reg, quote_next;

    // result register
    logic                       out_vld_reg;
    logic                       out_bs_reg;
    logic [1:0]                 out_beat_reg;
    logic                       out_echo_en_reg;
    logic [cle_pkg::CHAR_W-1:0] out_char_reg;
    logic                       out_store_reg;
    logic [7:0]                 out_index_reg;
    logic                       out_lr_reg;

    logic                       out_last, out_take, out_free, out_load;
    logic                       is_prompt, is_ign, is_eol, is_bs, pos_zero, full;
    logic                       need_out, proc;
    logic [CW-1:0]              cap_ext, cap_eff, pos_ext;
    logic [cle_pkg::CHAR_W-1:0] fold_char, quote_plain;
    logic                       is_lower;

    logic                       wr_en;
    logic [PW-1:0]              wr_addr, rd_addr;
    logic [cle_pkg::CHAR_W-1:0] wr_data, rd_data;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cap_reg <= cle_pkg::RST_LINE_CAPACITY;
            echo_en_reg  <= cle_pkg::RST_ECHO_ENABLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cle_pkg::REG_LINE_CAPACITY: line_cap_reg <= cfg_data;
                cle_pkg::REG_ECHO_ENABLE:   echo_en_reg  <= cfg_data[0];
            endcase
        end
    end

    // ---------------- decode ----------------
    assign is_prompt = (in_cmd_reg == cle_pkg::CMD_PROMPT);
    assign is_ign    = (in_char_reg == cle_pkg::CHAR_IGNORE);
    assign is_eol    = (in_char_reg == cle_pkg::CHAR_CR) ||
                       (in_char_reg == cle_pkg::CHAR_LF);
    assign is_bs     = (in_char_reg == cle_pkg::CHAR_BS);
    assign pos_zero  = (pos_reg == '0);

    assign cap_ext = CW'(line_cap_reg);
    assign cap_eff = (cap_ext > CW'(BUF_DEPTH)) ? CW'(BUF_DEPTH) : cap_ext;
    assign pos_ext = CW'(pos_reg);
    assign full    = (pos_ext >= cap_eff);

    assign is_lower = (in_char_reg >= cle_pkg::CHAR_LOWER_A) &&
                      (in_char_reg <= cle_pkg::CHAR_LOWER_Z);

    // quote tracking and case folding for a plain byte
    always_comb
    begin
        fold_char   = in_char_reg;
        quote_plain = quote_reg;
        priority if (in_char_reg == quote_reg)
        begin
            quote_plain = cle_pkg::NO_QUOTE;
        end
        else if ((in_char_reg == cle_pkg::CHAR_DQUOTE) ||
                 (in_char_reg == cle_pkg::CHAR_SQUOTE))
        begin
            quote_plain = in_char_reg;
        end
        else if ((quote_reg == cle_pkg::NO_QUOTE) && is_lower)
        begin
            fold_char = in_char_reg - cle_pkg::CHAR_LOWER_A + cle_pkg::CHAR_UPPER_A;
        end
        else
        begin
            fold_char = in_char_reg;
        end
    end

    // ---------------- handshake ----------------
    assign out_last = out_bs_reg ? (out_beat_reg == BEAT_LAST) : 1'b1;
    assign out_take = out_vld_reg && result.ready;
    assign out_free = !out_vld_reg || (out_take && out_last);

    assign need_out = !is_prompt && !is_ign &&
                      (is_eol || (is_bs && !pos_zero) || (!is_bs && !full));
    assign proc     = in_vld_reg && (!need_out || out_free);
    assign out_load = proc && need_out;

    assign key.ready = !in_vld_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (key.ready)
        begin
            in_vld_reg <= key.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key.ready && key.valid)
        begin
            in_cmd_reg  <= key.cmd;
            in_char_reg <= key.key_char;
        end
    end

    // ---------------- state update ----------------
    always_comb
    begin
        pos_next   = pos_reg;
        quote_next = quote_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = fold_char;
        if (proc)
        begin
            priority if (is_prompt)
            begin
                pos_next   = '0;
                quote_next = cle_pkg::NO_QUOTE;
            end
            else if (is_ign)
            begin
                pos_next = pos_reg;
            end
            else if (is_eol)
            begin
                wr_en   = 1'b1;
                wr_data = cle_pkg::CHAR_LF;
            end
            else if (is_bs)
            begin
                if (!pos_zero)
                begin
                    pos_next = pos_reg - PW'(1);
                    // rd_data holds the entry just below the write position
                    if (rd_data == quote_reg)
                    begin
                        quote_next = cle_pkg::NO_QUOTE;
                    end
                end
            end
            else if (!full)
            begin
                wr_en      = 1'b1;
                pos_next   = pos_reg + PW'(1);
                quote_next = quote_plain;
            end
            else
            begin
                pos_next = pos_reg;
            end
        end
    end

    // keep the read port one entry below the position of the next cycle
    assign rd_addr = (pos_next == '0) ? '0 : (pos_next - PW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            quote_reg <= cle_pkg::NO_QUOTE;
        end
        else
        begin
            pos_reg   <= pos_next;
            quote_reg <= quote_next;
        end
    end

    cle_line_ram #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_line_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            out_bs_reg   <= 1'b0;
            out_beat_reg <= BEAT_FIRST;
        end
        else if (out_load)
        begin
            out_vld_reg  <= 1'b1;
            out_bs_reg   <= is_bs;
            out_beat_reg <= BEAT_FIRST;
        end
        else if (out_take)
        begin
            if (out_last)
            begin
                out_vld_reg <= 1'b0;
            end
            else
            begin
                out_beat_reg <= out_beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_echo_en_reg <= echo_en_reg;
            out_char_reg    <= is_eol ? cle_pkg::CHAR_LF : fold_char;
            out_store_reg   <= !is_bs;
            out_index_reg   <= is_bs ? 8'd0 : pos_ext[7:0];
            out_lr_reg      <= is_eol;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.echo_valid  = out_echo_en_reg;
    assign result.echo_char   = !out_bs_reg ? out_char_reg :
                                (out_beat_reg == BEAT_MID) ? cle_pkg::CHAR_SPACE :
                                cle_pkg::CHAR_BS;
    assign result.store_valid = out_store_reg;
    assign result.store_index = out_index_reg;
    assign result.store_char  = out_store_reg ? out_char_reg : 8'd0;
    assign result.line_ready  = out_lr_reg;
    assign result.last        = out_last;

endmodule

>>> rtl/cle_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_line_ram
// Line buffer: one write port, one registered read port, with forwarding of
// a write that hits the address read in the same cycle.
// ----------------------------------------------------------------------------
module cle_line_ram #(
    parameter int DEPTH = cle_pkg::DEF_BUF_DEPTH + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [cle_pkg::CHAR_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [cle_pkg::CHAR_W-1:0] rd_data
);

    logic [cle_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [cle_pkg::CHAR_W-1:0] rd_q_reg;
    logic [cle_pkg::CHAR_W-1:0] byp_data_reg;
    logic                       byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_q_reg;

endmodule

>>> dv/tb_console_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_line_editor
// Self-checking bench for the console line editor. Keys go in over the key
// channel. A model of the line buffer, the write position and the open quote
// predicts every result beat, and each beat is compared field by field in
// order. A short directed run comes first. Random phases follow, each with
// its own capacity, echo setting and idle pattern. One phase fills the
// buffer to its end.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                       echo_valid;
    logic [cle_pkg::CHAR_W-1:0] echo_char;
    logic                       store_valid;
    logic [7:0]                 store_index;
    logic [cle_pkg::CHAR_W-1:0] store_char;
    logic                       line_ready;
    logic                       last;
} edit_beat_t;

// mirror of the editor state; queues the beats each key should produce
class line_edit_board;
    logic [cle_pkg::CHAR_W-1:0] line_copy [0:cle_pkg::DEF_BUF_DEPTH];
    int                         wr_pos;
    logic [cle_pkg::CHAR_W-1:0] quote_char;
    int                         capacity;
    logic                       echo_on;
    edit_beat_t                 due_beats [$];
    int                         errors;
    int                         beat_no;

    function new();
        foreach (line_copy[i])
            line_copy[i] = '0;
        wr_pos     = 0;
        quote_char = cle_pkg::NO_QUOTE;
        capacity   = cle_pkg::RST_LINE_CAPACITY;
        echo_on    = cle_pkg::RST_ECHO_ENABLE;
        errors     = 0;
        beat_no    = 0;
    endfunction

    function void set_regs(logic [7:0] cap, logic echo);
        capacity = cap;
        echo_on  = echo;
    endfunction

    function void queue_beat(logic [cle_pkg::CHAR_W-1:0] ec, logic sv, int si,
                             logic [cle_pkg::CHAR_W-1:0] sc, logic lr, logic lst);
        edit_beat_t b;
        b.echo_valid  = echo_on;
        b.echo_char   = ec;
        b.store_valid = sv;
        b.store_index = 8'(si);
        b.store_char  = sc;
        b.line_ready  = lr;
        b.last        = lst;
        due_beats.push_back(b);
    endfunction

    function void note_key(logic cmd, logic [cle_pkg::CHAR_W-1:0] key);
        int                         lim;
        int                         pos;
        logic [cle_pkg::CHAR_W-1:0] c;
        lim = (capacity > cle_pkg::DEF_BUF_DEPTH) ? cle_pkg::DEF_BUF_DEPTH : capacity;
        pos = (wr_pos > cle_pkg::DEF_BUF_DEPTH) ? cle_pkg::DEF_BUF_DEPTH : wr_pos;
        c   = key;
        if (cmd == cle_pkg::CMD_PROMPT)
        begin
            wr_pos     = 0;
            quote_char = cle_pkg::NO_QUOTE;
            return;
        end
        if (c == cle_pkg::CHAR_IGNORE)
            return;
        // line end: newline stored in place, position holds
        if (c == cle_pkg::CHAR_CR || c == cle_pkg::CHAR_LF)
        begin
            line_copy[pos] = cle_pkg::CHAR_LF;
            queue_beat(cle_pkg::CHAR_LF, 1'b1, pos, cle_pkg::CHAR_LF, 1'b1, 1'b1);
            return;
        end
        if (c == cle_pkg::CHAR_BS)
        begin
            if (pos == 0)
                return;
            pos--;
            wr_pos = pos;
            if (line_copy[pos] == quote_char)
                quote_char = cle_pkg::NO_QUOTE;
            queue_beat(cle_pkg::CHAR_BS, 1'b0, 0, '0, 1'b0, 1'b0);
            queue_beat(cle_pkg::CHAR_SPACE, 1'b0, 0, '0, 1'b0, 1'b0);
            queue_beat(cle_pkg::CHAR_BS, 1'b0, 0, '0, 1'b0, 1'b1);
            return;
        end
        if (pos >= lim)
            return;
        if (c == quote_char)
            quote_char = cle_pkg::NO_QUOTE;
        else if (c == cle_pkg::CHAR_DQUOTE || c == cle_pkg::CHAR_SQUOTE)
            quote_char = c;
        else if (quote_char == cle_pkg::NO_QUOTE &&
                 c >= cle_pkg::CHAR_LOWER_A && c <= cle_pkg::CHAR_LOWER_Z)
            c = c - cle_pkg::CHAR_LOWER_A + cle_pkg::CHAR_UPPER_A;
        line_copy[pos] = c;
        wr_pos         = pos + 1;
        queue_beat(c, 1'b1, pos, c, 1'b0, 1'b1);
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task field_check(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                             beat_no, name, got, want));
    endtask

    task check_beat(edit_beat_t got);
        edit_beat_t want;
        beat_no++;
        if (due_beats.size() == 0)
        begin
            report($sformatf("beat %0d arrived with nothing pending", beat_no));
            return;
        end
        want = due_beats.pop_front();
        field_check("echo_valid", 8'(got.echo_valid), 8'(want.echo_valid));
        field_check("echo_char", got.echo_char, want.echo_char);
        field_check("store_valid", 8'(got.store_valid), 8'(want.store_valid));
        field_check("store_index", got.store_index, want.store_index);
        field_check("store_char", got.store_char, want.store_char);
        field_check("line_ready", 8'(got.line_ready), 8'(want.line_ready));
        field_check("last", 8'(got.last), 8'(want.last));
    endtask
endclass

module tb_console_line_editor;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_KEYS    = 24;
    localparam int FILL_KEYS     = cle_pkg::DEF_BUF_DEPTH + 2;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [cle_pkg::CHAR_W-1:0] cfg_data;

    cle_key_if    key_ch ();
    cle_result_if res_ch ();

    line_edit_board board;
    idle_mode_t     idle_mode;
    int             cycle_cnt;
    edit_beat_t     seen;

    logic [7:0] phase_cap  [PHASES] = '{8'd1, 8'd128, 8'd255, 8'd7,
                                        8'd2, 8'd128, 8'd40, 8'd1};
    logic       phase_echo [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0,
                                        1'b1, 1'b0, 1'b1, 1'b1};

    console_line_editor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit src_gap();
        unique case (idle_mode)
            IDLE_SRC:  return chance(78);
            IDLE_BOTH: return chance(13);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit snk_stall();
        unique case (idle_mode)
            IDLE_SNK:  return chance(78);
            IDLE_BOTH: return chance(13);
            default:   return 1'b0;
        endcase
    endfunction

    always @(negedge clk)
        res_ch.ready <= !snk_stall();

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            seen.echo_valid  = res_ch.echo_valid;
            seen.echo_char   = res_ch.echo_char;
            seen.store_valid = res_ch.store_valid;
            seen.store_index = res_ch.store_index;
            seen.store_char  = res_ch.store_char;
            seen.line_ready  = res_ch.line_ready;
            seen.last        = res_ch.last;
            board.check_beat(seen);
        end
    end

    // called and returns at a falling edge; valid stays up for a following key
    task automatic send_key(logic cmd, logic [cle_pkg::CHAR_W-1:0] ch);
        while (src_gap())
        begin
            key_ch.valid <= 1'b0;
            @(negedge clk);
        end
        key_ch.valid    <= 1'b1;
        key_ch.cmd      <= cmd;
        key_ch.key_char <= ch;
        @(posedge clk);
        while (key_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_key(cmd, ch);
        @(negedge clk);
    endtask

    task automatic random_key();
        int                         roll;
        logic                       cmd;
        logic [cle_pkg::CHAR_W-1:0] ch;
        roll = $urandom_range(0, 99);
        cmd  = cle_pkg::CMD_CHAR;
        if (roll < 40)
            ch = 8'($urandom_range(cle_pkg::CHAR_LOWER_A, cle_pkg::CHAR_LOWER_Z));
        else if (roll < 50)
            ch = 8'($urandom_range(cle_pkg::CHAR_SPACE, 8'h7E));
        else if (roll < 58)
            ch = roll[0] ? cle_pkg::CHAR_SQUOTE : cle_pkg::CHAR_DQUOTE;
        else if (roll < 72)
            ch = cle_pkg::CHAR_BS;
        else if (roll < 78)
            ch = roll[0] ? cle_pkg::CHAR_CR : cle_pkg::CHAR_LF;
        else if (roll < 82)
        begin
            cmd = cle_pkg::CMD_PROMPT;
            ch  = 8'($urandom_range(0, 255));
        end
        else if (roll < 85)
            ch = cle_pkg::CHAR_IGNORE;
        else
            ch = 8'($urandom_range(0, 255));
        send_key(cmd, ch);
    endtask

    // both registers, back to back, while the editor is idle
    task automatic write_regs(logic [7:0] cap, logic echo);
        cfg_we    <= 1'b1;
        cfg_index <= cle_pkg::REG_LINE_CAPACITY;
        cfg_data  <= cap;
        @(negedge clk);
        cfg_index <= cle_pkg::REG_ECHO_ENABLE;
        cfg_data  <= {{(cle_pkg::CHAR_W-1){1'b0}}, echo};
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_regs(cap, echo);
    endtask

    // keys that give no beat may still be in flight, hence the extra cycles
    task automatic settle();
        key_ch.valid <= 1'b0;
        while (board.due_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_directed();
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_BS);        // backspace on an empty line
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_IGNORE);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_LOWER_A);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_LOWER_Z);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_UPPER_A);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::NO_QUOTE);       // zero byte matches "no quote"
        send_key(cle_pkg::CMD_CHAR, 8'h60);                   // neighbors of the a..z range
        send_key(cle_pkg::CMD_CHAR, 8'h7B);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_DQUOTE);
        send_key(cle_pkg::CMD_CHAR, 8'h71);                   // stays lower case in quotes
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_SQUOTE);    // other quote takes over
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_SQUOTE);    // and closes
        send_key(cle_pkg::CMD_CHAR, 8'h62);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_DQUOTE);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_BS);        // erasing the quote closes it
        send_key(cle_pkg::CMD_CHAR, 8'h63);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_BS);
        send_key(cle_pkg::CMD_CHAR, 8'h80);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_CR);
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_LF);
        send_key(cle_pkg::CMD_PROMPT, cle_pkg::CHAR_CR);      // key byte is don't-care here
        send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_BS);
        send_key(cle_pkg::CMD_CHAR, 8'h6D);
        send_key(cle_pkg::CMD_CHAR, 8'h6E);
        send_key(cle_pkg::CMD_CHAR, 8'h6F);
    endtask

    initial
    begin
        logic [7:0] cap;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = cle_pkg::REG_LINE_CAPACITY;
        cfg_data        = '0;
        key_ch.valid    = 1'b0;
        key_ch.cmd      = cle_pkg::CMD_CHAR;
        key_ch.key_char = '0;
        res_ch.ready    = 1'b0;
        idle_mode       = IDLE_NONE;
        cycle_cnt       = 0;
        board           = new();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_regs(cle_pkg::RST_LINE_CAPACITY, cle_pkg::RST_ECHO_ENABLE);
        run_directed();

        // phase 0 shrinks the capacity below the current position
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            cap = (p == 6) ? 8'($urandom_range(3, 127)) : phase_cap[p];
            write_regs(cap, phase_echo[p]);
            idle_mode = idle_mode_t'(p % 4);
            if (p == 2)
            begin
                // run the line up to the buffer end, then close it there
                send_key(cle_pkg::CMD_PROMPT, 8'($urandom_range(0, 255)));
                repeat (FILL_KEYS)
                    send_key(cle_pkg::CMD_CHAR,
                             8'($urandom_range(cle_pkg::CHAR_LOWER_A,
                                               cle_pkg::CHAR_LOWER_Z)));
                send_key(cle_pkg::CMD_CHAR, cle_pkg::CHAR_CR);
            end
            repeat (PHASE_KEYS) random_key();
        end
        settle();

        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> console_line_editor.f
rtl/cle_pkg.sv
rtl/cle_if.sv
rtl/cle_line_ram.sv
rtl/console_line_editor.sv
dv/tb_console_line_editor.sv
